### rtl/vaa_pkg.sv
package vaa_pkg;

   // CORDIC angle accumulator: one full turn is 2^ACC_WIDTH
   localparam int ACC_WIDTH  = 32;
   // fraction bits kept below the integer coordinates during rotation
   localparam int FRAC_BITS  = 24;
   // growth headroom for the CORDIC gain (about 1.65 * sqrt(2)) plus margin
   localparam int GUARD_BITS = 3;
   // number of entries in the arctangent table
   localparam int TABLE_LEN  = 24;

   typedef logic [ACC_WIDTH-1:0] acc_type;

   localparam acc_type HALF_TURN = acc_type'(32'h8000_0000);

   // control that travels with each request down the chain
   typedef struct packed {
      logic valid;
      logic zero_vector;
   } tag_type;

   // atan(2^-step) as a fraction of a full turn, scaled by 2^32 and rounded
   function automatic acc_type atan_turn(input int unsigned step);
      acc_type value;
      case (step)
         0:       value = 32'h2000_0000;
         1:       value = 32'h12E4_051E;
         2:       value = 32'h09FB_385B;
         3:       value = 32'h0511_11D4;
         4:       value = 32'h028B_0D43;
         5:       value = 32'h0145_D7E1;
         6:       value = 32'h00A2_F61E;
         7:       value = 32'h0051_7C55;
         8:       value = 32'h0028_BE53;
         9:       value = 32'h0014_5F2F;
         10:      value = 32'h000A_2F98;
         11:      value = 32'h0005_17CC;
         12:      value = 32'h0002_8BE6;
         13:      value = 32'h0001_45F3;
         14:      value = 32'h0000_A2FA;
         15:      value = 32'h0000_517D;
         16:      value = 32'h0000_28BE;
         17:      value = 32'h0000_145F;
         18:      value = 32'h0000_0A30;
         19:      value = 32'h0000_0518;
         20:      value = 32'h0000_028C;
         21:      value = 32'h0000_0146;
         22:      value = 32'h0000_00A3;
         23:      value = 32'h0000_0051;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

### rtl/vaa_cell.sv
// One CORDIC micro-rotation in vectoring mode, registered at its output.
module vaa_cell #(
   parameter int DATA_WIDTH = 44,
   parameter int STEP       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vaa_pkg::tag_type              up_tag,
   input  logic signed [DATA_WIDTH-1:0]  up_x,
   input  logic signed [DATA_WIDTH-1:0]  up_y,
   input  vaa_pkg::acc_type              up_acc,
   output vaa_pkg::tag_type              dn_tag,
   output logic signed [DATA_WIDTH-1:0]  dn_x,
   output logic signed [DATA_WIDTH-1:0]  dn_y,
   output vaa_pkg::acc_type              dn_acc
);

   localparam vaa_pkg::acc_type ATAN_STEP = vaa_pkg::atan_turn(STEP);

   logic signed [DATA_WIDTH-1:0] x_shift;
   logic signed [DATA_WIDTH-1:0] y_shift;
   logic                         rotate_cw;

   vaa_pkg::tag_type             tag_ff, tag_in;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   vaa_pkg::acc_type             acc_ff, acc_in;

   // arithmetic shifts floor toward minus infinity
   assign x_shift = up_x >>> STEP;
   assign y_shift = up_y >>> STEP;

   // y strictly positive: rotate clockwise and add the angle
   assign rotate_cw = !up_y[DATA_WIDTH-1] && (up_y != '0);

   always_comb begin
      tag_in = up_tag;
      if (rotate_cw) begin
         x_in   = up_x + y_shift;
         y_in   = up_y - x_shift;
         acc_in = up_acc + ATAN_STEP;
      end else begin
         x_in   = up_x - y_shift;
         y_in   = up_y + x_shift;
         acc_in = up_acc - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign dn_tag = tag_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_acc = acc_ff;

endmodule

### rtl/vector_angle_atan2_unit.sv
// Channel    | Ports                                       | Handshake
// -----------+---------------------------------------------+--------------------------------
// request    | req_start_x/y, req_end_x/y                  | taken when start & !busy
// response   | rsp_angle, rsp_zero_vector                  | rsp_valid, one cycle, no stall
//
// A request is taken every cycle; busy stays low.
// Stages: one front stage (difference and half-turn pre-rotation), one cell per
// micro-rotation (CORDIC_STEPS, capped at TABLE_LEN), one rounding stage.
// Synchronous reset clears the valid marks of every stage; data in flight is dropped.
// The receiver cannot stall, so each response shows for exactly one cycle.
module vector_angle_atan2_unit #(
   parameter int COORD_WIDTH  = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   output logic                          rsp_valid,
   output logic [ANGLE_WIDTH-1:0]        rsp_angle,
   output logic                          rsp_zero_vector
);

   localparam int STEPS = (CORDIC_STEPS < vaa_pkg::TABLE_LEN) ?
                          CORDIC_STEPS : vaa_pkg::TABLE_LEN;
   localparam int DATA_WIDTH = COORD_WIDTH + 1 + vaa_pkg::FRAC_BITS + vaa_pkg::GUARD_BITS;
   localparam vaa_pkg::acc_type ROUND_BIAS =
      vaa_pkg::acc_type'(1) << (vaa_pkg::ACC_WIDTH - 1 - ANGLE_WIDTH);

   // front stage
   logic signed [COORD_WIDTH:0]   diff_x;
   logic signed [COORD_WIDTH:0]   diff_y;
   logic signed [COORD_WIDTH:0]   rot_x;
   logic signed [COORD_WIDTH:0]   rot_y;
   vaa_pkg::tag_type              front_tag_ff, front_tag_in;
   logic signed [DATA_WIDTH-1:0]  front_x_ff, front_x_in;
   logic signed [DATA_WIDTH-1:0]  front_y_ff, front_y_in;
   vaa_pkg::acc_type              front_acc_ff, front_acc_in;

   // cell chain
   vaa_pkg::tag_type              chain_tag [0:STEPS];
   logic signed [DATA_WIDTH-1:0]  chain_x   [0:STEPS];
   logic signed [DATA_WIDTH-1:0]  chain_y   [0:STEPS];
   vaa_pkg::acc_type              chain_acc [0:STEPS];

   // output stage
   vaa_pkg::acc_type              rounded;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_WIDTH-1:0]        rsp_angle_ff, rsp_angle_in;
   logic                          rsp_zero_ff, rsp_zero_in;

   assign busy = 1'b0;

   // vector (dx, -dy); fold the left half-plane onto the right
   always_comb begin
      diff_x = (COORD_WIDTH+1)'(req_end_x) - (COORD_WIDTH+1)'(req_start_x);
      diff_y = (COORD_WIDTH+1)'(req_start_y) - (COORD_WIDTH+1)'(req_end_y);
      if (diff_x[COORD_WIDTH]) begin
         rot_x        = -diff_x;
         rot_y        = -diff_y;
         front_acc_in = vaa_pkg::HALF_TURN;
      end else begin
         rot_x        = diff_x;
         rot_y        = diff_y;
         front_acc_in = '0;
      end
      front_x_in               = DATA_WIDTH'(rot_x) <<< vaa_pkg::FRAC_BITS;
      front_y_in               = DATA_WIDTH'(rot_y) <<< vaa_pkg::FRAC_BITS;
      front_tag_in.valid       = start && !busy;
      front_tag_in.zero_vector = (diff_x == '0) && (diff_y == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_tag_ff <= '0;
      end else begin
         front_tag_ff <= front_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      front_x_ff   <= front_x_in;
      front_y_ff   <= front_y_in;
      front_acc_ff <= front_acc_in;
   end

   assign chain_tag[0] = front_tag_ff;
   assign chain_x[0]   = front_x_ff;
   assign chain_y[0]   = front_y_ff;
   assign chain_acc[0] = front_acc_ff;

   // one cell per micro-rotation
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      vaa_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .STEP       (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_tag (chain_tag[i]),
         .up_x   (chain_x[i]),
         .up_y   (chain_y[i]),
         .up_acc (chain_acc[i]),
         .dn_tag (chain_tag[i+1]),
         .dn_x   (chain_x[i+1]),
         .dn_y   (chain_y[i+1]),
         .dn_acc (chain_acc[i+1])
      );
   end

   // round half up to the output angle width; a full turn wraps to 0, a zero vector gives 0
   always_comb begin
      rounded      = chain_acc[STEPS] + ROUND_BIAS;
      rsp_valid_in = chain_tag[STEPS].valid;
      rsp_zero_in  = chain_tag[STEPS].zero_vector;
      if (chain_tag[STEPS].zero_vector) begin
         rsp_angle_in = '0;
      end else begin
         rsp_angle_in = rounded[vaa_pkg::ACC_WIDTH-1 -: ANGLE_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff <= rsp_angle_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_zero_vector = rsp_zero_ff;

endmodule

### rtl/vaa_checker.sv
// Port-level checks on request to response timing and the zero-length case.
module vaa_checker #(
   parameter int COORD_WIDTH  = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [COORD_WIDTH-1:0] req_start_x,
   input logic signed [COORD_WIDTH-1:0] req_start_y,
   input logic signed [COORD_WIDTH-1:0] req_end_x,
   input logic signed [COORD_WIDTH-1:0] req_end_y,
   input logic                          rsp_valid,
   input logic [ANGLE_WIDTH-1:0]        rsp_angle,
   input logic                          rsp_zero_vector
);

   localparam int LATENCY = ((CORDIC_STEPS < 24) ? CORDIC_STEPS : 24) + 2;

   logic accept;
   logic same_point;

   assign accept     = start && !busy;
   assign same_point = (req_start_x == req_end_x) && (req_start_y == req_end_y);

   // every request gets its response after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request without response after pipeline latency");

   // no response appears without a request that latency earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without matching request");

   // a zero-length request comes back flagged
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && same_point) |-> ##LATENCY (rsp_valid && rsp_zero_vector))
      else $error("zero-length request not flagged");

   // a flagged response carries angle 0
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_vector) |-> (rsp_angle == '0))
      else $error("zero-length response with nonzero angle");

endmodule

bind vector_angle_atan2_unit vaa_checker #(
   .COORD_WIDTH  (COORD_WIDTH),
   .ANGLE_WIDTH  (ANGLE_WIDTH),
   .CORDIC_STEPS (CORDIC_STEPS)
) u_vaa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_start_x     (req_start_x),
   .req_start_y     (req_start_y),
   .req_end_x       (req_end_x),
   .req_end_y       (req_end_y),
   .rsp_valid       (rsp_valid),
   .rsp_angle       (rsp_angle),
   .rsp_zero_vector (rsp_zero_vector)
);

### bench/tb_vector_angle_atan2_unit.sv
module tb_vector_angle_atan2_unit;

   localparam int COORD_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int STEPS      = 16;
   localparam int FRAC_W     = 24;
   localparam int LATENCY    = STEPS + 2;
   localparam int RANDOM_REQ = 1950;

   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // atan(2^-i) in units of 2^-32 of a full turn
   localparam logic [31:0] ATAN_STEP [24] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   typedef logic signed [COORD_W-1:0] coord_t;

   typedef struct {
      logic [ANGLE_W-1:0] angle;
      logic               zero_vector;
   } direction_t;

   // expected directions, oldest first
   class angle_scoreboard;
      direction_t pending_dirs[$];
      int         errors = 0;

      // CORDIC vectoring on the difference vector (dx, -dy)
      function void note_request(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
         longint     vx;
         longint     vy;
         longint     shx;
         longint     shy;
         logic [31:0] turn;
         direction_t dir;
         vx   = longint'(ex) - longint'(sx);
         vy   = longint'(sy) - longint'(ey);
         turn = '0;
         if (vx == 0 && vy == 0) begin
            dir.angle       = '0;
            dir.zero_vector = 1'b1;
         end else begin
            vx = vx * (longint'(1) << FRAC_W);
            vy = vy * (longint'(1) << FRAC_W);
            // left half plane: rotate by half a turn first
            if (vx < 0) begin
               vx   = -vx;
               vy   = -vy;
               turn = HALF_TURN;
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
               shx = vx >>> i;
               shy = vy >>> i;
               if (vy > 0) begin
                  vx   = vx + shy;
                  vy   = vy - shx;
                  turn = turn + ATAN_STEP[i];
               end else begin
                  vx   = vx - shy;
                  vy   = vy + shx;
                  turn = turn - ATAN_STEP[i];
               end
            end
            // round half up, a full turn wraps to zero
            turn            = turn + (32'h1 << (31 - ANGLE_W));
            dir.angle       = ANGLE_W'(turn >> (32 - ANGLE_W));
            dir.zero_vector = 1'b0;
         end
         pending_dirs.push_back(dir);
      endfunction

      function void check_response(logic [ANGLE_W-1:0] angle, logic zero_vector);
         direction_t want;
         if (pending_dirs.size() == 0) begin
            $display("%0t: response with no request pending: angle %h zero_vector %b",
                     $time, angle, zero_vector);
            errors++;
         end else begin
            want = pending_dirs.pop_front();
            if (angle !== want.angle) begin
               $display("%0t: angle mismatch: expected %h actual %h",
                        $time, want.angle, angle);
               errors++;
            end
            if (zero_vector !== want.zero_vector) begin
               $display("%0t: zero_vector mismatch: expected %b actual %b",
                        $time, want.zero_vector, zero_vector);
               errors++;
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   coord_t             req_start_x = '0;
   coord_t             req_start_y = '0;
   coord_t             req_end_x   = '0;
   coord_t             req_end_y   = '0;
   logic               rsp_valid;
   logic [ANGLE_W-1:0] rsp_angle;
   logic               rsp_zero_vector;

   angle_scoreboard sb = new();
   int              burst_left = 0;

   always #1 clock = ~clock;

   vector_angle_atan2_unit #(
      .COORD_WIDTH (COORD_W),
      .ANGLE_WIDTH (ANGLE_W),
      .CORDIC_STEPS(STEPS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_angle      (rsp_angle),
      .rsp_zero_vector(rsp_zero_vector)
   );

   // monitor: values seen at the edge are the ones the block samples
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_start_x, req_start_y, req_end_x, req_end_y);
         if (rsp_valid)
            sb.check_response(rsp_angle, rsp_zero_vector);
      end
   end

   // random gap, then one request held until taken
   task automatic issue_request(input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (pick < 8) begin
         burst_left = $urandom_range(20, 60);
         gap = 0;
      end else if (pick < 40)
         gap = 0;
      else if (pick < 92)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (busy);
   endtask

   function automatic coord_t any_coord();
      return COORD_W'($urandom);
   endfunction

   function automatic coord_t near_coord(coord_t base, int span);
      return COORD_W'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic coord_t corner_coord();
      int pick;
      pick = $urandom_range(0, 2);
      if (pick == 0)
         return coord_t'(-32768);
      else if (pick == 1)
         return coord_t'(32767);
      return any_coord();
   endfunction

   initial begin : main
      coord_t sx, sy, ex, ey;
      int     kind;
      int     wait_cycles;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero-length vectors
      issue_request(0, 0, 0, 0);
      issue_request(-32768, -32768, -32768, -32768);
      issue_request(32767, 32767, 32767, 32767);
      // axes and diagonals
      issue_request(0, 0, 100, 0);
      issue_request(0, 0, 0, -100);
      issue_request(0, 0, -100, 0);
      issue_request(0, 0, 0, 100);
      issue_request(0, 0, 50, -50);
      issue_request(0, 0, -50, -50);
      issue_request(0, 0, -50, 50);
      issue_request(0, 0, 50, 50);
      // largest differences
      issue_request(-32768, 0, 32767, 0);
      issue_request(32767, 0, -32768, 0);
      issue_request(0, 32767, 0, -32768);
      issue_request(0, -32768, 0, 32767);
      issue_request(-32768, 32767, 32767, -32768);
      issue_request(32767, -32768, -32768, 32767);
      issue_request(-32768, -32768, 32767, 32767);
      // just off the x axis: wrap near a full turn and half-turn pre-rotation
      issue_request(0, 0, 32767, 1);
      issue_request(0, 0, 32767, -1);
      issue_request(0, 0, -32768, 1);
      issue_request(0, 0, -32768, -1);
      // unit vectors
      issue_request(0, 0, 1, 0);
      issue_request(0, 0, -1, 0);
      issue_request(5, 7, 5, 8);

      for (int n = 0; n < RANDOM_REQ; n++) begin
         kind = $urandom_range(0, 99);
         sx   = any_coord();
         sy   = any_coord();
         if (kind < 55) begin
            ex = any_coord();
            ey = any_coord();
         end else if (kind < 75) begin
            // short vectors, coarse angle steps
            ex = near_coord(sx, 8);
            ey = near_coord(sy, 8);
         end else if (kind < 83) begin
            ex = sx;
            ey = sy;
         end else if (kind < 92) begin
            // on an axis
            if ($urandom_range(0, 1)) begin
               ex = sx;
               ey = any_coord();
            end else begin
               ex = any_coord();
               ey = sy;
            end
         end else begin
            sx = corner_coord();
            sy = corner_coord();
            ex = corner_coord();
            ey = corner_coord();
         end
         issue_request(sx, sy, ex, ey);
      end
      start <= 1'b0;

      // drain, then watch for stray responses
      while (sb.pending_dirs.size() != 0)
         @(posedge clock);
      wait_cycles = LATENCY + 8;
      repeat (wait_cycles) @(posedge clock);
      if (sb.pending_dirs.size() != 0) begin
         $display("%0t: %0d responses still expected", $time, sb.pending_dirs.size());
         sb.errors++;
      end

      if (sb.errors == 0)
         $display("tb_vector_angle_atan2_unit: clean");
      else
         $display("tb_vector_angle_atan2_unit: errors");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_vector_angle_atan2_unit: errors");
      $finish;
   end

endmodule

### vector_angle_atan2_unit.f
rtl/vaa_pkg.sv
rtl/vaa_cell.sv
rtl/vector_angle_atan2_unit.sv
rtl/vaa_checker.sv
bench/tb_vector_angle_atan2_unit.sv
